// ===== sv/svfv_pkg.sv =====
// Shared types and constants for the sampled-values frame validator.
// No dependencies; imported by the parser, the result queue and the top level.
package svfv_pkg;

    // parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HEAD  = 3'd1;
    localparam logic [2:0] PH_TAG   = 3'd2;
    localparam logic [2:0] PH_LEN1  = 3'd3;
    localparam logic [2:0] PH_LENN  = 3'd4;
    localparam logic [2:0] PH_VALUE = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // nesting level of the BER walk
    localparam logic [2:0] CX_PDU    = 3'd0;
    localparam logic [2:0] CX_NOASDU = 3'd1;
    localparam logic [2:0] CX_SEQ    = 3'd2;
    localparam logic [2:0] CX_ASDU   = 3'd3;
    localparam logic [2:0] CX_FIELD  = 3'd4;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_NOT_SV   = 4'd2;
    localparam logic [3:0] ST_BAD_PDU  = 4'd3;
    localparam logic [3:0] ST_BAD_HDR  = 4'd4;
    localparam logic [3:0] ST_BAD_ASDU = 4'd5;
    localparam logic [3:0] ST_BAD_FLD  = 4'd6;
    localparam logic [3:0] ST_QUALITY  = 4'd7;
    localparam logic [3:0] ST_COUNT    = 4'd8;
    localparam logic [3:0] ST_SVID_LONG = 4'd9;

    // tags
    localparam logic [7:0] TAG_PDU      = 8'h60;
    localparam logic [7:0] TAG_SEQ      = 8'hA2;
    localparam logic [7:0] TAG_ASDU     = 8'h30;
    localparam logic [7:0] TAG_SVID     = 8'h80;
    localparam logic [7:0] TAG_DATSET   = 8'h81;
    localparam logic [7:0] TAG_SMPCNT   = 8'h82;
    localparam logic [7:0] TAG_CONFREV  = 8'h83;
    localparam logic [7:0] TAG_REFRTM   = 8'h84;
    localparam logic [7:0] TAG_SMPSYNCH = 8'h85;
    localparam logic [7:0] TAG_SMPRATE  = 8'h86;
    localparam logic [7:0] TAG_DATA     = 8'h87;
    localparam logic [7:0] TAG_SMPMOD   = 8'h88;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_SV   = 16'h88BA;
    localparam logic [4:0]  HB_PLAIN = 5'd14;
    localparam logic [4:0]  HB_VLAN  = 5'd18;
    localparam logic [4:0]  FOUND_ALL = 5'h1F;
    localparam int          MIN_FRAME_BYTES = 64;

    typedef struct packed {
        logic [3:0]  status;
        logic [47:0] dest_mac;
        logic [15:0] app_id;
        logic [15:0] asdu_count;
        logic [31:0] conf_rev;
        logic [15:0] sample_count;
        logic [10:0] svid_offset;
        logic [7:0]  svid_length;
    } svfv_result_t;

    // error reported for a fault at a given nesting level
    function automatic logic [3:0] ctx_error(input logic [2:0] ctx);
        logic [3:0] e;
        case (ctx)
            CX_PDU:    e = ST_BAD_PDU;
            CX_NOASDU: e = ST_BAD_HDR;
            CX_SEQ:    e = ST_BAD_HDR;
            CX_ASDU:   e = ST_BAD_ASDU;
            default:   e = ST_BAD_FLD;
        endcase
        return e;
    endfunction

    // tag expected at the outer levels
    function automatic logic [7:0] want_tag(input logic [2:0] ctx);
        logic [7:0] t;
        case (ctx)
            CX_PDU:    t = TAG_PDU;
            CX_NOASDU: t = TAG_SVID;
            CX_SEQ:    t = TAG_SEQ;
            default:   t = TAG_ASDU;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/sampled_values_frame_validator.sv =====
// Top level of the sampled-values frame validator: config registers, parser, queue.
// Depends on svfv_pkg, svfv_parser and svfv_out_queue.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one frame byte per beat with
//   frame_length and last_byte; one result beat leaves on the output channel
//   (out_valid / out_stall) for each beat marked last_byte.
//   Throughput is one byte per cycle while in_stall is low: each byte is
//   handled in a single pass of the parser logic between its state
//   registers and the result queue. A result is pushed into the queue when
//   its last byte is accepted and is shown after any older queued result.
//   Results wait in a two-entry queue; in_stall rises only when both entries
//   are full, so a stalled receiver holds the queue and back-pressures input.
//   The config channel (cfg_valid / cfg_ready) is always ready; index 0 is the
//   sample data field length, index 1 the good quality word. Write it only
//   while no frame is in flight.
//   Reset clears the parser and the queue and loads the register defaults;
//   the svID store needs no clearing, each frame writes before it reads.
module sampled_values_frame_validator #(
    parameter int MAX_SVID_BYTES  = 128,
    parameter int MAX_FRAME_BYTES = 2048,
    parameter int CHANNEL_BYTES   = 8,
    parameter int VALUE_BYTES     = 4,
    parameter int QUALITY_BYTES   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [11:0] frame_length,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [47:0] dest_mac,
    output logic [15:0] app_id,
    output logic [15:0] asdu_count,
    output logic [31:0] conf_rev,
    output logic [15:0] sample_count,
    output logic [10:0] svid_offset,
    output logic [7:0]  svid_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import svfv_pkg::*;

    localparam logic CFG_DATA_LEN = 1'b0;
    localparam logic CFG_QUALITY  = 1'b1;

    logic [10:0]  data_field_length_reg;
    logic [31:0]  quality_good_value_reg;
    logic         accept;
    logic         full;
    logic         res_valid;
    svfv_result_t res;
    svfv_result_t out_data;

    assign cfg_ready = 1'b1;
    assign in_stall = full;
    assign accept = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_field_length_reg <= 11'd64;
            quality_good_value_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DATA_LEN: data_field_length_reg <= cfg_data[10:0];
                CFG_QUALITY:  quality_good_value_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    svfv_parser #(
        .MAX_SVID_BYTES  (MAX_SVID_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CHANNEL_BYTES   (CHANNEL_BYTES),
        .VALUE_BYTES     (VALUE_BYTES),
        .QUALITY_BYTES   (QUALITY_BYTES)
    ) u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .data_byte          (data_byte),
        .frame_length       (frame_length),
        .last_byte          (last_byte),
        .data_field_length  (data_field_length_reg),
        .quality_good_value (quality_good_value_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    svfv_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // result beat fields
    assign status       = out_data.status;
    assign dest_mac     = out_data.dest_mac;
    assign app_id       = out_data.app_id;
    assign asdu_count   = out_data.asdu_count;
    assign conf_rev     = out_data.conf_rev;
    assign sample_count = out_data.sample_count;
    assign svid_offset  = out_data.svid_offset;
    assign svid_length  = out_data.svid_length;

endmodule

// ===== sv/svfv_parser.sv =====
// Byte-wide frame parser: header checks, BER walk, svID store and verdict.
// Depends on svfv_pkg.
module svfv_parser #(
    parameter int MAX_SVID_BYTES  = 128,
    parameter int MAX_FRAME_BYTES = 2048,
    parameter int CHANNEL_BYTES   = 8,
    parameter int VALUE_BYTES     = 4,
    parameter int QUALITY_BYTES   = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic [11:0]           frame_length,
    input  logic                  last_byte,
    input  logic [10:0]           data_field_length,
    input  logic [31:0]           quality_good_value,
    output logic                  res_valid,
    output svfv_pkg::svfv_result_t res
);
    import svfv_pkg::*;

    localparam int SV_AW = (MAX_SVID_BYTES > 1) ? $clog2(MAX_SVID_BYTES) : 1;
    localparam int CH_W  = (CHANNEL_BYTES > 1) ? $clog2(CHANNEL_BYTES) : 1;
    localparam bit QUAL_ON = (QUALITY_BYTES <= CHANNEL_BYTES);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  ctx_reg, ctx_next;
    logic [11:0] pos_reg, pos_next;
    logic [11:0] frame_end_reg, frame_end_next;
    logic [4:0]  hdr_base_reg, hdr_base_next;
    logic [11:0] pdu_end_reg, pdu_end_next;
    logic [11:0] seq_end_reg, seq_end_next;
    logic [11:0] asdu_end_reg, asdu_end_next;
    logic [11:0] vstart_reg, vstart_next;
    logic [11:0] vend_reg, vend_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  octets_reg, octets_next;
    logic [7:0]  prev_tag_reg, prev_tag_next;
    logic [4:0]  found_reg, found_next;
    logic [7:0]  first_len_reg, first_len_next;
    logic [11:0] svid_off_reg, svid_off_next;
    logic [15:0] declared_reg, declared_next;
    logic [15:0] seen_reg, seen_next;
    logic [31:0] first_conf_reg, first_conf_next;
    logic [15:0] first_smp_reg, first_smp_next;
    logic [31:0] cur_conf_reg, cur_conf_next;
    logic [15:0] cur_smp_reg, cur_smp_next;
    logic [31:0] fvs_reg, fvs_next;
    logic [31:0] qword_reg, qword_next;
    logic [CH_W-1:0] ch_cnt_reg, ch_cnt_next;
    logic        differs_reg, differs_next;
    logic [3:0]  err_reg, err_next;
    logic [47:0] mac_reg, mac_next;
    logic [15:0] app_reg, app_next;

    // svID store
    logic [7:0]       svid_mem [MAX_SVID_BYTES];
    logic             mem_we;
    logic [SV_AW-1:0] mem_waddr;
    logic [SV_AW-1:0] mem_raddr;
    logic [7:0]       mem_rdata_reg;
    logic [11:0]      rd_off;

    function automatic logic [11:0] region(input logic [2:0] ctx, input logic [11:0] fe,
                                           input logic [11:0] pe, input logic [11:0] se,
                                           input logic [11:0] ae);
        logic [11:0] l;
        case (ctx)
            CX_PDU:    l = fe;
            CX_NOASDU: l = pe;
            CX_SEQ:    l = pe;
            CX_ASDU:   l = se;
            default:   l = ae;
        endcase
        return l;
    endfunction

    // next-state logic for one accepted beat
    always_comb
    begin
        logic [11:0] p;
        logic [11:0] lim;
        logic [11:0] room;
        logic [11:0] lenp;
        logic [11:0] off;
        logic        fin;
        logic        bv;
        logic        hfail;
        logic [CH_W-1:0] r;

        phase_next = phase_reg;       ctx_next = ctx_reg;
        pos_next = pos_reg;           frame_end_next = frame_end_reg;
        hdr_base_next = hdr_base_reg; pdu_end_next = pdu_end_reg;
        seq_end_next = seq_end_reg;   asdu_end_next = asdu_end_reg;
        vstart_next = vstart_reg;     vend_next = vend_reg;
        acc_next = acc_reg;           octets_next = octets_reg;
        prev_tag_next = prev_tag_reg; found_next = found_reg;
        first_len_next = first_len_reg; svid_off_next = svid_off_reg;
        declared_next = declared_reg; seen_next = seen_reg;
        first_conf_next = first_conf_reg; first_smp_next = first_smp_reg;
        cur_conf_next = cur_conf_reg; cur_smp_next = cur_smp_reg;
        fvs_next = fvs_reg;           qword_next = qword_reg;
        ch_cnt_next = ch_cnt_reg;     differs_next = differs_reg;
        err_next = err_reg;           mac_next = mac_reg;
        app_next = app_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        res_valid = 1'b0;
        res = '0;
        p = '0; lim = '0; room = '0; lenp = '0; off = '0;
        fin = 1'b0; bv = 1'b0; hfail = 1'b0; r = '0;

        if (accept)
        begin
            // frame start
            if (phase_reg == PH_IDLE)
            begin
                pos_next = '0; frame_end_next = frame_length; hdr_base_next = '0;
                pdu_end_next = '0; seq_end_next = '0; asdu_end_next = '0;
                vstart_next = '0; vend_next = '0; acc_next = '0; octets_next = '0;
                prev_tag_next = '0; found_next = '0; first_len_next = '0;
                svid_off_next = '0; declared_next = '0; seen_next = '0;
                first_conf_next = '0; first_smp_next = '0; cur_conf_next = '0;
                cur_smp_next = '0; fvs_next = '0; qword_next = '0; ch_cnt_next = '0;
                differs_next = 1'b0; err_next = ST_OK; mac_next = '0; app_next = '0;
                ctx_next = CX_PDU;
                phase_next = PH_HEAD;
                if (32'(frame_length) < MIN_FRAME_BYTES
                    || 32'(frame_length) > MAX_FRAME_BYTES)
                begin
                    err_next = ST_SHORT;
                    phase_next = PH_DONE;
                end
            end

            if (phase_next != PH_DONE)
            begin
                p = pos_next;
                pos_next = p + 12'd1;

                // byte handling by phase
                case (phase_next)
                    PH_HEAD:
                    begin
                        if (p < 12'd6)
                            mac_next = {mac_next[39:0], data_byte};
                        if (p == 12'd12)
                            fvs_next = {24'd0, data_byte};
                        if (p == 12'd13)
                        begin
                            if ({fvs_next[7:0], data_byte} == ETH_VLAN)
                                hdr_base_next = HB_VLAN;
                            else if ({fvs_next[7:0], data_byte} == ETH_SV)
                                hdr_base_next = HB_PLAIN;
                            else
                                hfail = 1'b1;
                        end
                        if (!hfail && hdr_base_next == HB_VLAN && p == 12'd16)
                            fvs_next = {24'd0, data_byte};
                        if (!hfail && hdr_base_next == HB_VLAN && p == 12'd17
                            && {fvs_next[7:0], data_byte} != ETH_SV)
                            hfail = 1'b1;
                        if (hfail)
                        begin
                            err_next = ST_NOT_SV;
                            phase_next = PH_DONE;
                        end
                        else if (hdr_base_next != 5'd0)
                        begin
                            if (p == 12'(hdr_base_next))
                                app_next[15:8] = data_byte;
                            if (p == 12'(hdr_base_next) + 12'd1)
                                app_next[7:0] = data_byte;
                            if (p == 12'(hdr_base_next) + 12'd7)
                            begin
                                ctx_next = CX_PDU;
                                phase_next = PH_TAG;
                            end
                        end
                    end
                    PH_TAG:
                    begin
                        if (ctx_next == CX_FIELD)
                        begin
                            if (data_byte <= prev_tag_next)
                            begin
                                err_next = ST_BAD_FLD;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                prev_tag_next = data_byte;
                                phase_next = PH_LEN1;
                            end
                        end
                        else if (data_byte != want_tag(ctx_next))
                        begin
                            err_next = ctx_error(ctx_next);
                            phase_next = PH_DONE;
                        end
                        else
                            phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        if (!data_byte[7])
                        begin
                            acc_next = {24'd0, data_byte};
                            fin = 1'b1;
                        end
                        else
                        begin
                            lim = region(ctx_next, frame_end_next, pdu_end_next,
                                         seq_end_next, asdu_end_next);
                            room = lim - pos_next;
                            if (data_byte[6:0] == 7'd0 || data_byte[6:0] > 7'd4
                                || {5'd0, data_byte[6:0]} > room)
                            begin
                                err_next = ctx_error(ctx_next);
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                octets_next = data_byte[2:0];
                                acc_next = '0;
                                phase_next = PH_LENN;
                            end
                        end
                    end
                    PH_LENN:
                    begin
                        acc_next = {acc_next[23:0], data_byte};
                        octets_next = octets_next - 3'd1;
                        if (octets_next == 3'd0)
                            fin = 1'b1;
                    end
                    PH_VALUE:
                    begin
                        off = p - vstart_next;
                        fvs_next = {fvs_next[23:0], data_byte};
                        if (ctx_next == CX_FIELD && prev_tag_next == TAG_SVID)
                        begin
                            if (seen_next == 16'd0)
                            begin
                                if (32'(off) < MAX_SVID_BYTES)
                                begin
                                    mem_we = 1'b1;
                                    mem_waddr = off[SV_AW-1:0];
                                end
                            end
                            else if (!differs_next)
                            begin
                                if (32'(off) >= MAX_SVID_BYTES || mem_rdata_reg != data_byte)
                                    differs_next = 1'b1;
                            end
                        end
                        else if (ctx_next == CX_FIELD && prev_tag_next == TAG_DATA
                                 && 32'(off) >= VALUE_BYTES && QUAL_ON)
                        begin
                            // quality word of each channel
                            r = ch_cnt_next;
                            ch_cnt_next = (32'(r) == CHANNEL_BYTES - 1) ? '0 : r + 1'b1;
                            if (r == '0)
                                qword_next = '0;
                            if (32'(r) < QUALITY_BYTES)
                                qword_next = {qword_next[23:0], data_byte};
                            if (32'(r) == QUALITY_BYTES - 1
                                && qword_next != quality_good_value)
                            begin
                                err_next = ST_QUALITY;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // complete length: bound check, then act on it
                if (fin)
                begin
                    lim = region(ctx_next, frame_end_next, pdu_end_next,
                                 seq_end_next, asdu_end_next);
                    room = lim - pos_next;
                    lenp = pos_next + acc_next[11:0];
                    if (acc_next > {20'd0, room})
                    begin
                        err_next = ctx_error(ctx_next);
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        case (ctx_next)
                            CX_PDU:
                            begin
                                pdu_end_next = lenp;
                                ctx_next = CX_NOASDU;
                                phase_next = PH_TAG;
                            end
                            CX_NOASDU:
                            begin
                                if (acc_next == 32'd0 || acc_next > 32'd2)
                                begin
                                    err_next = ST_BAD_HDR;
                                    phase_next = PH_DONE;
                                end
                                else
                                    bv = 1'b1;
                            end
                            CX_SEQ:
                            begin
                                seq_end_next = lenp;
                                if (lenp != pdu_end_next)
                                begin
                                    err_next = ST_BAD_HDR;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    ctx_next = CX_ASDU;
                                    phase_next = PH_TAG;
                                end
                            end
                            CX_ASDU:
                            begin
                                asdu_end_next = lenp;
                                ctx_next = CX_FIELD;
                                phase_next = PH_TAG;
                                prev_tag_next = '0;
                                found_next = '0;
                                differs_next = 1'b0;
                                cur_conf_next = '0;
                                cur_smp_next = '0;
                            end
                            default:
                            begin
                                bv = 1'b1;
                                case (prev_tag_next)
                                    TAG_SVID:
                                    begin
                                        if (acc_next == 32'd0)
                                            bv = 1'b0;
                                        else if (seen_next == 16'd0)
                                        begin
                                            if (acc_next > MAX_SVID_BYTES)
                                            begin
                                                bv = 1'b0;
                                                err_next = ST_SVID_LONG;
                                                phase_next = PH_DONE;
                                            end
                                            else
                                            begin
                                                first_len_next = acc_next[7:0];
                                                svid_off_next = pos_next;
                                            end
                                        end
                                        else if (acc_next != {24'd0, first_len_next})
                                            differs_next = 1'b1;
                                        if (bv)
                                            found_next[0] = 1'b1;
                                    end
                                    TAG_DATSET:  bv = (acc_next != 32'd0);
                                    TAG_SMPCNT:
                                    begin
                                        bv = (acc_next == 32'd2);
                                        found_next[1] = found_next[1] | bv;
                                    end
                                    TAG_CONFREV:
                                    begin
                                        bv = (acc_next == 32'd4);
                                        found_next[2] = found_next[2] | bv;
                                    end
                                    TAG_REFRTM:  bv = (acc_next == 32'd8);
                                    TAG_SMPSYNCH:
                                    begin
                                        bv = (acc_next == 32'd1);
                                        found_next[3] = found_next[3] | bv;
                                    end
                                    TAG_SMPRATE: bv = (acc_next == 32'd2);
                                    TAG_SMPMOD:  bv = (acc_next == 32'd2);
                                    TAG_DATA:
                                    begin
                                        bv = (acc_next == {21'd0, data_field_length});
                                        found_next[4] = found_next[4] | bv;
                                    end
                                    default:     bv = 1'b0;
                                endcase
                                if (!bv && phase_next != PH_DONE)
                                begin
                                    err_next = ST_BAD_FLD;
                                    phase_next = PH_DONE;
                                end
                            end
                        endcase
                        // open a value
                        if (bv)
                        begin
                            vstart_next = pos_next;
                            vend_next = lenp;
                            fvs_next = '0;
                            qword_next = '0;
                            ch_cnt_next = '0;
                            phase_next = PH_VALUE;
                        end
                    end
                end

                // value finished
                if (phase_next == PH_VALUE && pos_next >= vend_next)
                begin
                    if (ctx_next == CX_NOASDU)
                    begin
                        declared_next = fvs_next[15:0];
                        if (fvs_next[15:0] == 16'd0)
                        begin
                            err_next = ST_BAD_HDR;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            ctx_next = CX_SEQ;
                            phase_next = PH_TAG;
                        end
                    end
                    else
                    begin
                        if (prev_tag_next == TAG_SMPCNT)
                            cur_smp_next = fvs_next[15:0];
                        else if (prev_tag_next == TAG_CONFREV)
                            cur_conf_next = fvs_next;
                        phase_next = PH_TAG;
                    end
                end

                // container end reached
                if (phase_next inside {PH_TAG, PH_LEN1, PH_LENN})
                begin
                    lim = region(ctx_next, frame_end_next, pdu_end_next,
                                 seq_end_next, asdu_end_next);
                    if (pos_next >= lim)
                    begin
                        if (phase_next != PH_TAG)
                        begin
                            err_next = ctx_error(ctx_next);
                            phase_next = PH_DONE;
                        end
                        else if (ctx_next == CX_FIELD)
                        begin
                            // close the ASDU
                            if (found_next != FOUND_ALL)
                            begin
                                err_next = ST_BAD_FLD;
                                phase_next = PH_DONE;
                            end
                            else if (seen_next != 16'd0
                                     && (differs_next || cur_conf_next != first_conf_next))
                            begin
                                err_next = ST_BAD_FLD;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                if (seen_next == 16'd0)
                                begin
                                    first_conf_next = cur_conf_next;
                                    first_smp_next = cur_smp_next;
                                end
                                seen_next = seen_next + 16'd1;
                                ctx_next = CX_ASDU;
                                if (pos_next >= seq_end_next)
                                begin
                                    err_next = (seen_next == declared_next) ? ST_OK : ST_COUNT;
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        else if (ctx_next == CX_ASDU)
                        begin
                            err_next = (seen_next == declared_next) ? ST_OK : ST_COUNT;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            err_next = ctx_error(ctx_next);
                            phase_next = PH_DONE;
                        end
                    end
                end
            end

            // verdict on the last beat
            if (last_byte)
            begin
                res_valid = 1'b1;
                res.status = (phase_next == PH_DONE) ? err_next : ST_SHORT;
                if (res.status == ST_OK)
                begin
                    res.dest_mac = mac_next;
                    res.app_id = app_next;
                    res.asdu_count = declared_next;
                    res.conf_rev = first_conf_next;
                    res.sample_count = first_smp_next;
                    res.svid_offset = svid_off_next[10:0];
                    res.svid_length = first_len_next;
                end
                phase_next = PH_IDLE;
            end
        end
    end

    // read address of the next value byte
    assign rd_off = pos_next - vstart_next;
    assign mem_raddr = rd_off[SV_AW-1:0];

    // svID store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            svid_mem[mem_waddr] <= data_byte;
        mem_rdata_reg <= svid_mem[mem_raddr];
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;       ctx_reg <= CX_PDU;
            pos_reg <= '0;              frame_end_reg <= '0;
            hdr_base_reg <= '0;         pdu_end_reg <= '0;
            seq_end_reg <= '0;          asdu_end_reg <= '0;
            vstart_reg <= '0;           vend_reg <= '0;
            acc_reg <= '0;              octets_reg <= '0;
            prev_tag_reg <= '0;         found_reg <= '0;
            first_len_reg <= '0;        svid_off_reg <= '0;
            declared_reg <= '0;         seen_reg <= '0;
            first_conf_reg <= '0;       first_smp_reg <= '0;
            cur_conf_reg <= '0;         cur_smp_reg <= '0;
            fvs_reg <= '0;              qword_reg <= '0;
            ch_cnt_reg <= '0;           differs_reg <= 1'b0;
            err_reg <= ST_OK;           mac_reg <= '0;
            app_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;       ctx_reg <= ctx_next;
            pos_reg <= pos_next;           frame_end_reg <= frame_end_next;
            hdr_base_reg <= hdr_base_next; pdu_end_reg <= pdu_end_next;
            seq_end_reg <= seq_end_next;   asdu_end_reg <= asdu_end_next;
            vstart_reg <= vstart_next;     vend_reg <= vend_next;
            acc_reg <= acc_next;           octets_reg <= octets_next;
            prev_tag_reg <= prev_tag_next; found_reg <= found_next;
            first_len_reg <= first_len_next; svid_off_reg <= svid_off_next;
            declared_reg <= declared_next; seen_reg <= seen_next;
            first_conf_reg <= first_conf_next; first_smp_reg <= first_smp_next;
            cur_conf_reg <= cur_conf_next; cur_smp_reg <= cur_smp_next;
            fvs_reg <= fvs_next;           qword_reg <= qword_next;
            ch_cnt_reg <= ch_cnt_next;     differs_reg <= differs_next;
            err_reg <= err_next;           mac_reg <= mac_next;
            app_reg <= app_next;
        end
    end

endmodule

// ===== sv/svfv_out_queue.sv =====
// Two-entry result register queue between the parser and the output channel.
// Depends on svfv_pkg.
module svfv_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  svfv_pkg::svfv_result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output svfv_pkg::svfv_result_t out_data
);
    import svfv_pkg::*;

    svfv_result_t slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign full = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = slot_reg[rd_ptr_reg];
    assign pop = out_valid && !out_stall;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
